### rtl/core/thm_pkg.sv
// Shared types and constants for the thermostat mode controller.
`timescale 1ns / 1ps

package thm_pkg;

  localparam int TEMP_W     = 12;
  localparam int REL_W      = 10;
  localparam int BLINK_W    = 16;
  localparam int TIME_W     = 32;
  localparam int CMP_W      = 14;  // temperature plus window or margin, no overflow
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_HEAT = 3'd1,
    MODE_STAB = 3'd2,
    MODE_TGT  = 3'd3,
    MODE_HOT  = 3'd4
  } mode_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_HEAT_ON_BELOW    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAT_OFF_AT      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERHEAT_AT      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERHEAT_RELEASE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEAT_BLINK_MS    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_STAB_BLINK_MS    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOT_BLINK_MS     = 3'd7;

  localparam logic signed [TEMP_W-1:0] RST_HEAT_ON_BELOW    = 12'sd448;
  localparam logic signed [TEMP_W-1:0] RST_HEAT_OFF_AT      = 12'sd496;
  localparam logic signed [TEMP_W-1:0] RST_OVERHEAT_AT      = 12'sd560;
  localparam logic signed [TEMP_W-1:0] RST_SETPOINT         = 12'sd480;
  localparam logic [REL_W-1:0]         RST_OVERHEAT_RELEASE = 10'd32;
  localparam logic [BLINK_W-1:0]       RST_HEAT_BLINK_MS    = 16'd75;
  localparam logic [BLINK_W-1:0]       RST_STAB_BLINK_MS    = 16'd200;
  localparam logic [BLINK_W-1:0]       RST_HOT_BLINK_MS     = 16'd38;

  typedef struct packed {
    logic signed [TEMP_W-1:0] heat_on_below;
    logic signed [TEMP_W-1:0] heat_off_at;
    logic signed [TEMP_W-1:0] overheat_at;
    logic signed [TEMP_W-1:0] setpoint;
    logic [REL_W-1:0]         overheat_release;
    logic [BLINK_W-1:0]       heat_blink_ms;
    logic [BLINK_W-1:0]       stab_blink_ms;
    logic [BLINK_W-1:0]       hot_blink_ms;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  led;
    logic  toggled;
  } step_t;

endpackage

### rtl/core/thm_cfg.sv
// Configuration register bank for the thermostat mode controller.
`timescale 1ns / 1ps

module thm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [thm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [thm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output thm_pkg::cfg_t                     cfg
);

  thm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heat_on_below    <= thm_pkg::RST_HEAT_ON_BELOW;
      cfg_r.heat_off_at      <= thm_pkg::RST_HEAT_OFF_AT;
      cfg_r.overheat_at      <= thm_pkg::RST_OVERHEAT_AT;
      cfg_r.setpoint         <= thm_pkg::RST_SETPOINT;
      cfg_r.overheat_release <= thm_pkg::RST_OVERHEAT_RELEASE;
      cfg_r.heat_blink_ms    <= thm_pkg::RST_HEAT_BLINK_MS;
      cfg_r.stab_blink_ms    <= thm_pkg::RST_STAB_BLINK_MS;
      cfg_r.hot_blink_ms     <= thm_pkg::RST_HOT_BLINK_MS;
    end else if (cfg_we) begin
      case (cfg_addr)
        thm_pkg::CFG_HEAT_ON_BELOW:
          cfg_r.heat_on_below <= $signed(cfg_wdata[thm_pkg::TEMP_W-1:0]);
        thm_pkg::CFG_HEAT_OFF_AT:
          cfg_r.heat_off_at <= $signed(cfg_wdata[thm_pkg::TEMP_W-1:0]);
        thm_pkg::CFG_OVERHEAT_AT:
          cfg_r.overheat_at <= $signed(cfg_wdata[thm_pkg::TEMP_W-1:0]);
        thm_pkg::CFG_SETPOINT:
          cfg_r.setpoint <= $signed(cfg_wdata[thm_pkg::TEMP_W-1:0]);
        thm_pkg::CFG_OVERHEAT_RELEASE:
          cfg_r.overheat_release <= cfg_wdata[thm_pkg::REL_W-1:0];
        thm_pkg::CFG_HEAT_BLINK_MS:
          cfg_r.heat_blink_ms <= cfg_wdata[thm_pkg::BLINK_W-1:0];
        thm_pkg::CFG_STAB_BLINK_MS:
          cfg_r.stab_blink_ms <= cfg_wdata[thm_pkg::BLINK_W-1:0];
        thm_pkg::CFG_HOT_BLINK_MS:
          cfg_r.hot_blink_ms <= cfg_wdata[thm_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/thm_fsm.sv
// Next-mode and LED decision logic for one temperature sample.
`timescale 1ns / 1ps

module thm_fsm #(
  parameter int unsigned TARGET_WINDOW = 8
) (
  input  thm_pkg::cfg_t                       cfg,
  input  logic signed [thm_pkg::TEMP_W-1:0]   temp,
  input  logic [thm_pkg::TIME_W-1:0]          now_ms,
  input  thm_pkg::mode_t                      cur_mode,
  input  logic [thm_pkg::TIME_W-1:0]          last_toggle_ms,
  input  logic                                led_level,
  output thm_pkg::step_t                      res
);

  localparam int EXT_W = thm_pkg::CMP_W - thm_pkg::TEMP_W;
  localparam int REL_EXT_W = thm_pkg::CMP_W - thm_pkg::REL_W;

  logic signed [thm_pkg::CMP_W-1:0] t_x, lo_x, hi_x, oh_x, tg_x, win_x, rel_x;
  logic signed [thm_pkg::CMP_W-1:0] win_lo, win_hi, rel_lim;
  logic [thm_pkg::TIME_W-1:0]       elapsed;
  logic [thm_pkg::BLINK_W-1:0]      interval;
  logic                             below_lo, at_hi, at_oh, in_win, below_rel, due;
  thm_pkg::mode_t                   next_mode;

  assign t_x   = $signed({{EXT_W{temp[thm_pkg::TEMP_W-1]}}, temp});
  assign lo_x  = $signed({{EXT_W{cfg.heat_on_below[thm_pkg::TEMP_W-1]}}, cfg.heat_on_below});
  assign hi_x  = $signed({{EXT_W{cfg.heat_off_at[thm_pkg::TEMP_W-1]}}, cfg.heat_off_at});
  assign oh_x  = $signed({{EXT_W{cfg.overheat_at[thm_pkg::TEMP_W-1]}}, cfg.overheat_at});
  assign tg_x  = $signed({{EXT_W{cfg.setpoint[thm_pkg::TEMP_W-1]}}, cfg.setpoint});
  assign win_x = $signed(thm_pkg::CMP_W'(TARGET_WINDOW));
  assign rel_x = $signed({{REL_EXT_W{1'b0}}, cfg.overheat_release});

  assign win_lo  = tg_x - win_x;
  assign win_hi  = tg_x + win_x;
  assign rel_lim = oh_x - rel_x;

  assign below_lo  = t_x < lo_x;
  assign at_hi     = t_x >= hi_x;
  assign at_oh     = t_x >= oh_x;
  assign in_win    = (t_x >= win_lo) && (t_x <= win_hi);
  assign below_rel = t_x < rel_lim;

  // next mode
  always_comb begin
    next_mode = cur_mode;
    case (cur_mode)
      thm_pkg::MODE_HEAT: begin
        if (at_oh) next_mode = thm_pkg::MODE_HOT;
        else if (at_hi) next_mode = thm_pkg::MODE_STAB;
      end
      thm_pkg::MODE_STAB: begin
        if (below_lo) next_mode = thm_pkg::MODE_HEAT;
        else if (at_oh) next_mode = thm_pkg::MODE_HOT;
        else if (in_win) next_mode = thm_pkg::MODE_TGT;
      end
      thm_pkg::MODE_HOT: begin
        if (below_rel) next_mode = thm_pkg::MODE_IDLE;
      end
      default: begin
        // idle and target reached share the same exits
        if (below_lo) next_mode = thm_pkg::MODE_HEAT;
        else if (at_oh) next_mode = thm_pkg::MODE_HOT;
      end
    endcase
  end

  assign elapsed = now_ms - last_toggle_ms;

  // LED outputs
  always_comb begin
    interval    = cfg.hot_blink_ms;
    res.mode    = next_mode;
    res.led     = led_level;
    res.toggled = 1'b0;
    case (next_mode)
      thm_pkg::MODE_HEAT: interval = cfg.heat_blink_ms;
      thm_pkg::MODE_STAB: interval = cfg.stab_blink_ms;
      default:            interval = cfg.hot_blink_ms;
    endcase
    due = elapsed >= {{(thm_pkg::TIME_W - thm_pkg::BLINK_W){1'b0}}, interval};
    case (next_mode)
      thm_pkg::MODE_HEAT, thm_pkg::MODE_STAB, thm_pkg::MODE_HOT: begin
        if (due) begin
          res.led     = ~led_level;
          res.toggled = 1'b1;
        end
      end
      thm_pkg::MODE_TGT: res.led = 1'b1;
      default:           res.led = 1'b0;
    endcase
  end

endmodule

### rtl/core/thermostat_mode_controller.sv
// Top level of the thermostat mode controller.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one temperature sample per beat. in_tdata carries the
//   signed temperature and the millisecond timestamp, in_tuser the sensor
//   fault flag. A faulted beat is taken and dropped: no result, no change.
//   Result channel out_*: one beat per good sample with mode, mode change,
//   heater drive, LED level and buzzer enable.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr on the
//   clock edge; write only while no sample is in flight.
//   Path: each sample passes the input register, then the result register.
//   Throughput: one sample per cycle while results are taken; the mode, LED
//   and toggle-time state update in the same cycle the sample leaves the
//   input register, so the next sample sees it right away.
//   Stall: when out_tready is low the result holds, the input register
//   fills and in_tready drops until the result is taken.
//   Reset (rst_n low, synchronous): mode idle, LED off, toggle time zero,
//   both stages empty, registers at their default thresholds and intervals.

module thermostat_mode_controller #(
  parameter int unsigned TARGET_WINDOW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // [11:0] temperature, [43:12] now_ms, [47:44] zero
  input  logic [thm_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] sensor_fault
  input  logic [0:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] mode, [3] mode_changed, [4] heater_on, [5] led_on, [6] buzzer_on, [7] zero
  output logic [thm_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [thm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [thm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  thm_pkg::cfg_t                      cfg;
  thm_pkg::step_t                     res;

  logic                               s1_valid_r;
  logic signed [thm_pkg::TEMP_W-1:0]  s1_temp_r;
  logic [thm_pkg::TIME_W-1:0]         s1_now_r;

  thm_pkg::mode_t                     mode_r, mode_nxt;
  logic                               led_r, led_nxt;
  logic [thm_pkg::TIME_W-1:0]         last_toggle_r, last_toggle_nxt;

  logic                               out_tvalid_r;
  logic [thm_pkg::OUT_DATA_W-1:0]     out_tdata_r;

  logic                               out_free, fire, in_acc;

  thm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  thm_fsm #(
    .TARGET_WINDOW (TARGET_WINDOW)
  ) u_fsm (
    .cfg            (cfg),
    .temp           (s1_temp_r),
    .now_ms         (s1_now_r),
    .cur_mode       (mode_r),
    .last_toggle_ms (last_toggle_r),
    .led_level      (led_r),
    .res            (res)
  );

  assign out_free  = !out_tvalid_r || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    mode_nxt        = mode_r;
    led_nxt         = led_r;
    last_toggle_nxt = last_toggle_r;
    if (fire) begin
      mode_nxt = res.mode;
      led_nxt  = res.led;
      if (res.toggled) last_toggle_nxt = s1_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
      mode_r        <= thm_pkg::MODE_IDLE;
      led_r         <= 1'b0;
      last_toggle_r <= '0;
    end else begin
      // drop faulted beats at the door
      if (in_tready) s1_valid_r <= in_tvalid && !in_tuser[0];
      if (out_free) out_tvalid_r <= fire;
      mode_r        <= mode_nxt;
      led_r         <= led_nxt;
      last_toggle_r <= last_toggle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_temp_r <= $signed(in_tdata[thm_pkg::TEMP_W-1:0]);
      s1_now_r  <= in_tdata[thm_pkg::TEMP_W +: thm_pkg::TIME_W];
    end
    if (fire) begin
      out_tdata_r <= {1'b0,
                      res.mode == thm_pkg::MODE_HOT,
                      res.led,
                      res.mode == thm_pkg::MODE_HEAT,
                      res.mode != mode_r,
                      res.mode};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
